// ===== hdl/extexp_pkg.sv =====
// A shared side-payload type, floating-point constants and a helper function for the split exponential.
package extexp_pkg;

  localparam int CELL_COUNT = 8;

  localparam logic [31:0] LOG2E     = 32'h3FB8AA3B;
  localparam logic [31:0] M_LN2_HI  = 32'hBF317218;
  localparam logic [31:0] LN2_LO    = 32'h3102E308;
  localparam logic [31:0] K0        = 32'h3F800000;
  localparam logic [31:0] K1        = 32'h3F7FFFFB;
  localparam logic [31:0] K2        = 32'h3EFFFEE3;
  localparam logic [31:0] K3        = 32'h3E2AAD40;
  localparam logic [31:0] K4        = 32'h3D2B9D0D;
  localparam logic [31:0] K5        = 32'h3C07CFCE;
  localparam logic [31:0] NEG_ZERO  = 32'h80000000;
  localparam logic [31:0] QNAN      = 32'h7FC00000;
  localparam logic [31:0] ROUND_MIN = 32'h4B000000;

  // Addends of the last four Horner steps, in chain order.
  localparam logic [3:0][31:0] POLY_ADD = {K0, K1, K2, K3};

  typedef struct packed {
    logic [31:0] x_bits;
    logic [31:0] n_bits;
    logic [31:0] t_bits;
  } side_t;

  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] n;
    logic       found;
    n     = 5'd24;
    found = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = 5'(23 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

// ===== hdl/extexp_fma_cell.sv =====
// Six-stage binary32 fused multiply-add cell with a side payload carried alongside.
module extexp_fma_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [31:0]          a_i,
  input  logic [31:0]          b_i,
  input  logic [31:0]          c_i,
  input  extexp_pkg::side_t    side_i,
  output logic                 valid_o,
  output logic [31:0]          r_o,
  output extexp_pkg::side_t    side_o
);

  typedef logic signed [11:0] scale_t;

  typedef struct packed {
    logic        sign;
    logic        nan;
    logic        inf;
    logic        zero;
    logic [23:0] mant;
    scale_t      scale;
  } opnd_t;

  function automatic opnd_t unpack(input logic [31:0] f);
    opnd_t      o;
    logic [4:0] lz;
    logic [23:0] m;
    logic [7:0] eb;
    m       = {f[30:23] != 8'd0, f[22:0]};
    lz      = extexp_pkg::lzc24(m);
    eb      = (f[30:23] == 8'd0) ? 8'd1 : f[30:23];
    o.sign  = f[31];
    o.nan   = (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
    o.inf   = (f[30:23] == 8'hFF) && (f[22:0] == 23'd0);
    o.zero  = (f[30:0] == 31'd0);
    o.mant  = m << lz;
    o.scale = scale_t'({4'd0, eb}) - scale_t'(150) - scale_t'({7'd0, lz});
    return o;
  endfunction

  function automatic logic [6:0] lzc101(input logic [100:0] v);
    logic [6:0] n;
    logic       found;
    n     = 7'd101;
    found = 1'b0;
    for (int i = 100; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = 7'(100 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  logic [5:0]        v_q;
  extexp_pkg::side_t side_q [6];
  logic              spec_q [5];
  logic [31:0]       spec_bits_q [5];

  // Stage A: unpack and normalise operands, resolve special values.
  opnd_t       oa, ob, oc;
  logic        psign, nan, pinf, pzero, spec_d;
  logic [31:0] spec_bits_d;
  logic [23:0] ma_q, mb_q, mc_q;
  scale_t      sab_q, sca_q;
  logic        psign_a_q, csign_a_q, czero_a_q;

  always_comb begin
    oa    = unpack(a_i);
    ob    = unpack(b_i);
    oc    = unpack(c_i);
    psign = oa.sign ^ ob.sign;
    pinf  = oa.inf | ob.inf;
    pzero = oa.zero | ob.zero;
    nan   = oa.nan | ob.nan | oc.nan | (oa.inf & ob.zero) | (oa.zero & ob.inf) |
            (pinf & oc.inf & (psign != oc.sign));
    spec_d      = 1'b1;
    spec_bits_d = extexp_pkg::QNAN;
    priority if (nan) begin
      spec_bits_d = extexp_pkg::QNAN;
    end else if (pinf) begin
      spec_bits_d = {psign, 8'hFF, 23'd0};
    end else if (oc.inf) begin
      spec_bits_d = c_i;
    end else if (pzero) begin
      spec_bits_d = oc.zero ? {psign & oc.sign, 31'd0} : c_i;
    end else begin
      spec_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q      <= oa.mant;
      mb_q      <= ob.mant;
      mc_q      <= oc.mant;
      sab_q     <= oa.scale + ob.scale;
      sca_q     <= oc.scale;
      psign_a_q <= psign;
      csign_a_q <= oc.sign;
      czero_a_q <= oc.zero;
    end
  end

  // Stage B: significand product and addend position.
  logic [47:0] prod_q;
  scale_t      pos_q, spb_q, scb_q;
  logic [23:0] mc_b_q;
  logic        psign_b_q, csign_b_q, czero_b_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q    <= ma_q * mb_q;
      pos_q     <= sca_q - sab_q + scale_t'(26);
      spb_q     <= sab_q;
      scb_q     <= sca_q;
      mc_b_q    <= mc_q;
      psign_b_q <= psign_a_q;
      csign_b_q <= csign_a_q;
      czero_b_q <= czero_a_q;
    end
  end

  // Stage C: alignment into a 101-bit window and signed addition.
  logic [100:0] pw, cw, sum_d;
  scale_t       lsb_d;
  logic         sign_d;
  logic [100:0] sum_q;
  scale_t       lsb_q;
  logic         sign_c_q;

  always_comb begin
    pw    = 101'(prod_q) << 26;
    cw    = '0;
    lsb_d = spb_q - scale_t'(26);
    priority if (czero_b_q) begin
      cw = '0;
    end else if (pos_q > scale_t'(76)) begin
      cw    = 101'(mc_b_q) << 76;
      pw    = 101'd1;
      lsb_d = scb_q - scale_t'(76);
    end else if (pos_q < scale_t'(0)) begin
      cw = 101'd1;
    end else begin
      cw = 101'(mc_b_q) << pos_q[6:0];
    end
    if (psign_b_q == csign_b_q) begin
      sum_d  = pw + cw;
      sign_d = psign_b_q;
    end else if (pw >= cw) begin
      sum_d  = pw - cw;
      sign_d = psign_b_q;
    end else begin
      sum_d  = cw - pw;
      sign_d = csign_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q    <= sum_d;
      lsb_q    <= lsb_d;
      sign_c_q <= sign_d;
    end
  end

  // Stage D: leading-zero count of the sum.
  logic [100:0] sum_dq;
  logic [6:0]   lz_q;
  scale_t       lsb_dq;
  logic         sign_dq, zero_dq;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_dq  <= sum_q;
      lz_q    <= lzc101(sum_q);
      lsb_dq  <= lsb_q;
      sign_dq <= sign_c_q;
      zero_dq <= (sum_q == '0);
    end
  end

  // Stage E: normalising shift and biased exponent.
  logic [100:0] norm_q;
  scale_t       exp_q;
  logic         sign_e_q, zero_e_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      norm_q   <= sum_dq << lz_q;
      exp_q    <= lsb_dq + scale_t'(227) - scale_t'({5'd0, lz_q});
      sign_e_q <= sign_dq;
      zero_e_q <= zero_dq;
    end
  end

  // Stage F: subnormal shift, rounding to nearest even and packing.
  scale_t       kk;
  logic [100:0] shifted;
  logic         dropped, rnd, st, up, ovf;
  logic [23:0]  mant24;
  logic [7:0]   eadj;
  logic [30:0]  enc;
  logic [31:0]  r_d, r_q;

  always_comb begin
    kk      = (exp_q < scale_t'(1)) ? scale_t'(1) - exp_q : scale_t'(0);
    shifted = norm_q;
    dropped = 1'b0;
    if (kk > scale_t'(30)) begin
      shifted = '0;
      dropped = (norm_q != '0);
    end else begin
      shifted = norm_q >> kk[4:0];
      dropped = ((norm_q & ~({101{1'b1}} << kk[4:0])) != '0);
    end
    mant24 = shifted[100:77];
    rnd    = shifted[76];
    st     = (shifted[75:0] != '0) | dropped;
    up     = rnd & (st | mant24[0]);
    eadj   = (exp_q >= scale_t'(1) && exp_q <= scale_t'(254)) ? exp_q[7:0] - 8'd1 : 8'd0;
    enc    = {eadj, 23'd0} + {7'd0, mant24} + 31'(up);
    ovf    = (exp_q > scale_t'(254)) || (enc[30:23] == 8'hFF);
    priority if (spec_q[4]) begin
      r_d = spec_bits_q[4];
    end else if (zero_e_q) begin
      r_d = 32'd0;
    end else if (ovf) begin
      r_d = {sign_e_q, 8'hFF, 23'd0};
    end else begin
      r_d = {sign_e_q, enc};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q <= r_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0]      <= side_i;
      spec_q[0]      <= spec_d;
      spec_bits_q[0] <= spec_bits_d;
      for (int i = 1; i < 6; i++) begin
        side_q[i] <= side_q[i-1];
      end
      for (int i = 1; i < 5; i++) begin
        spec_q[i]      <= spec_q[i-1];
        spec_bits_q[i] <= spec_bits_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  assign valid_o = v_q[5];
  assign r_o     = r_q;
  assign side_o  = side_q[5];

endmodule

// ===== hdl/extexp_round_cell.sv =====
// Two-stage round-to-nearest-even of a binary32 value to an integer, result placed in the side payload.
module extexp_round_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [31:0]       v_i,
  input  extexp_pkg::side_t side_i,
  output logic              valid_o,
  output extexp_pkg::side_t side_o
);

  logic [1:0]        v_q;
  extexp_pkg::side_t side_q [2];

  logic        pass_d;
  logic [4:0]  sh;
  logic [23:0] mant, ip, below_mask;
  logic        half, below, up;
  logic [23:0] k_d;

  always_comb begin
    pass_d     = ({1'b0, v_i[30:0]} >= extexp_pkg::ROUND_MIN);
    mant       = {1'b1, v_i[22:0]};
    sh         = 5'd24;
    ip         = '0;
    half       = 1'b0;
    below      = 1'b0;
    below_mask = '0;
    up         = 1'b0;
    k_d        = '0;
    if (v_i[30:23] >= 8'd126 && !pass_d) begin
      sh         = 5'(8'd150 - v_i[30:23]);
      ip         = mant >> sh;
      half       = mant[sh - 5'd1];
      below_mask = ~(24'hFFFFFF << (sh - 5'd1));
      below      = ((mant & below_mask) != 24'd0);
      up         = half & (below | ip[0]);
      k_d        = ip + 24'(up);
    end
  end

  logic [23:0] k_q;
  logic        sign_q, pass_q;
  logic [31:0] vin_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      k_q    <= k_d;
      sign_q <= v_i[31];
      pass_q <= pass_d;
      vin_q  <= v_i;
    end
  end

  logic [4:0]  lz;
  logic [23:0] kn;
  logic [31:0] n_d, n_q;

  always_comb begin
    lz = extexp_pkg::lzc24(k_q);
    kn = k_q << lz;
    priority if (pass_q) begin
      n_d = vin_q;
    end else if (k_q == 24'd0) begin
      n_d = {sign_q, 31'd0};
    end else begin
      n_d = {sign_q, 8'(8'd150 - {3'd0, lz}), kn[22:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q       <= n_d;
      side_q[0] <= side_i;
      side_q[1] <= side_q[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[0], valid_i};
    end
  end

  assign valid_o = v_q[1];

  always_comb begin
    side_o        = side_q[1];
    side_o.n_bits = n_q;
  end

endmodule

// ===== hdl/extexp_f32_split_mantissa_exponent.sv =====
// Top level: chain of fused multiply-add cells computing exp(x) as mantissa and exponent.
// An accepted request passes through eight six-stage cells
// and a two-stage rounding cell. Throughput is one request per cycle while the output is not stalled.
// A stalled result freezes the whole chain; requests are taken whenever it moves.
// Reset clears only the valid flags of every stage; data registers are not reset.
module extexp_f32_split_mantissa_exponent (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] x_bits_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] mantissa_bits_o,
  output logic [31:0] exponent_bits_o
);

  localparam int Cells = extexp_pkg::CELL_COUNT;

  logic              en;
  logic [31:0]       op_a [Cells];
  logic [31:0]       op_b [Cells];
  logic [31:0]       op_c [Cells];
  logic [31:0]       res  [Cells];
  logic              v_in [Cells];
  logic              v_out [Cells];
  extexp_pkg::side_t s_in [Cells];
  extexp_pkg::side_t s_out [Cells];
  extexp_pkg::side_t rnd_side;
  logic              rnd_valid;

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  extexp_round_cell u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_out[0]),
    .v_i     (res[0]),
    .side_i  (s_out[0]),
    .valid_o (rnd_valid),
    .side_o  (rnd_side)
  );

  for (genvar g = 0; g < Cells; g++) begin : g_cell
    if (g == 0) begin : g_scale
      assign op_a[g] = x_bits_i;
      assign op_b[g] = extexp_pkg::LOG2E;
      assign op_c[g] = extexp_pkg::NEG_ZERO;
      assign s_in[g] = '{x_bits: x_bits_i, n_bits: 32'd0, t_bits: 32'd0};
      assign v_in[g] = in_valid_i;
    end else if (g == 1) begin : g_hi
      assign op_a[g] = rnd_side.n_bits;
      assign op_b[g] = extexp_pkg::M_LN2_HI;
      assign op_c[g] = rnd_side.x_bits;
      assign s_in[g] = rnd_side;
      assign v_in[g] = rnd_valid;
    end else if (g == 2 || g == 3) begin : g_red
      extexp_pkg::side_t prev;
      assign prev = '{x_bits: s_out[g-1].x_bits, n_bits: s_out[g-1].n_bits,
                      t_bits: res[g-1]};
      assign op_a[g] = (g == 2) ? prev.n_bits : extexp_pkg::K5;
      assign op_b[g] = (g == 2) ? extexp_pkg::LN2_LO : prev.t_bits;
      assign op_c[g] = (g == 2) ? prev.t_bits : extexp_pkg::K4;
      assign s_in[g] = prev;
      assign v_in[g] = v_out[g-1];
    end else begin : g_horner
      assign op_a[g] = res[g-1];
      assign op_b[g] = s_out[g-1].t_bits;
      assign op_c[g] = extexp_pkg::POLY_ADD[2'(g - 4)];
      assign s_in[g] = s_out[g-1];
      assign v_in[g] = v_out[g-1];
    end

    extexp_fma_cell u_fma (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v_in[g]),
      .a_i     (op_a[g]),
      .b_i     (op_b[g]),
      .c_i     (op_c[g]),
      .side_i  (s_in[g]),
      .valid_o (v_out[g]),
      .r_o     (res[g]),
      .side_o  (s_out[g])
    );
  end

  assign out_valid_o     = v_out[Cells-1];
  assign mantissa_bits_o = res[Cells-1];
  assign exponent_bits_o = s_out[Cells-1].n_bits;

endmodule

// ===== hdl/extexp_checker.sv =====
// Port-level checker for the split exponential, bound to the top level.
module extexp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [31:0] x_bits_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] mantissa_bits_o,
  input logic [31:0] exponent_bits_o
);

  // A result that is held back must stay put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mantissa_bits_o) &&
      $stable(exponent_bits_o))
    else $error("stalled result changed");

  // Requests are refused only while a finished result is held back.
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("request refused without a held result");

  // An infinite or NaN exponent always comes with a NaN mantissa.
  a_nan_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && exponent_bits_o[30:23] == 8'hFF |-> mantissa_bits_o == 32'h7FC00000)
    else $error("non-finite exponent without NaN mantissa");

  // A finite exponent is an integer: zero or at least one in magnitude.
  a_integer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && exponent_bits_o[30:23] != 8'hFF |->
      exponent_bits_o[30:23] >= 8'd127 || exponent_bits_o[30:0] == 31'd0)
    else $error("exponent is not integer valued");

endmodule

bind extexp_f32_split_mantissa_exponent extexp_checker u_checker (.*);

// ===== verif/extexp_f32_split_mantissa_exponent_checker.sv =====
// Checker for the split exponential: predicts mantissa and exponent of each request and compares.
module extexp_f32_split_mantissa_exponent_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] x_bits_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] mantissa_bits_i,
  input  logic [31:0] exponent_bits_i,
  output int          fail_count_o,
  output int          pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] mantissa;
    logic [31:0] exponent;
  } split_exp_t;

  split_exp_t expected_q[$];
  int         fail_count;

  function automatic logic is_nan(logic [31:0] v);
    return v[30:23] == 8'hFF && v[22:0] != 0;
  endfunction

  function automatic logic is_inf(logic [31:0] v);
    return v[30:0] == 31'h7F800000;
  endfunction

  // Single-precision a*b+c with one rounding to nearest even, computed exactly on a wide grid
  // whose least significant bit weighs 2^-298.
  function automatic logic [31:0] fused_mul_add(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    logic         sp;
    logic         ssum;
    int           ea, eb, ec, msb, shift;
    logic [23:0]  ma, mb, mc;
    logic [599:0] pv, cv, sum, mant, mask;
    logic         guard, sticky;
    logic [63:0]  enc;
    sp = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b) || is_nan(c)) return extexp_pkg::QNAN;
    if (is_inf(a) || is_inf(b)) begin
      if (a[30:0] == 0 || b[30:0] == 0) return extexp_pkg::QNAN;
      if (is_inf(c) && c[31] != sp) return extexp_pkg::QNAN;
      return {sp, 31'h7F800000};
    end
    if (is_inf(c)) return c;
    if (a[30:0] == 0 || b[30:0] == 0) begin
      if (c[30:0] == 0) return {sp & c[31], 31'b0};
      return c;
    end
    ea = (a[30:23] == 0) ? 1 : int'(a[30:23]);
    eb = (b[30:23] == 0) ? 1 : int'(b[30:23]);
    ec = (c[30:23] == 0) ? 1 : int'(c[30:23]);
    ma = {a[30:23] != 0, a[22:0]};
    mb = {b[30:23] != 0, b[22:0]};
    mc = {c[30:23] != 0, c[22:0]};
    pv = 600'(48'(ma) * 48'(mb)) << (ea + eb - 2);
    cv = 600'(mc) << (ec + 148);
    if (sp == c[31]) begin
      sum  = pv + cv;
      ssum = sp;
    end else if (pv >= cv) begin
      sum  = pv - cv;
      ssum = sp;
    end else begin
      sum  = cv - pv;
      ssum = c[31];
    end
    if (sum == 0) return 32'h0;
    msb = 0;
    for (int i = 599; i >= 0; i--) begin
      if (sum[i]) begin
        msb = i;
        break;
      end
    end
    shift  = (msb - 23 < 149) ? 149 : msb - 23;
    mant   = sum >> shift;
    guard  = sum[shift-1];
    mask   = (600'b1 << (shift - 1)) - 1;
    sticky = |(sum & mask);
    if (guard && (sticky || mant[0])) mant = mant + 1;
    enc = (64'(shift - 149) << 23) + mant[63:0];
    if (enc >= 64'h7F800000) return {ssum, 31'h7F800000};
    return {ssum, enc[30:0]};
  endfunction

  function automatic logic [31:0] round_half_even(logic [31:0] v);
    int          e, s, p;
    logic [31:0] m, k, rem, half;
    if (v[30:0] >= extexp_pkg::ROUND_MIN[30:0]) return v;
    e = int'(v[30:23]);
    if (e < 126) return {v[31], 31'b0};
    m    = {8'b1, v[22:0]};
    s    = 150 - e;
    k    = m >> s;
    rem  = m & ((32'b1 << s) - 1);
    half = 32'b1 << (s - 1);
    if (rem > half || (rem == half && k[0])) k = k + 1;
    if (k == 0) return {v[31], 31'b0};
    p = 0;
    for (int i = 0; i < 32; i++) if (k[i]) p = i;
    return {v[31], 8'(p + 127), 23'(k << (23 - p))};
  endfunction

  function automatic logic [31:0] canonical(logic [31:0] v);
    return is_nan(v) ? extexp_pkg::QNAN : v;
  endfunction

  function automatic split_exp_t split_exp(logic [31:0] x);
    logic [31:0] n, t, p;
    split_exp_t  r;
    n = round_half_even(fused_mul_add(x, extexp_pkg::LOG2E, extexp_pkg::NEG_ZERO));
    t = fused_mul_add(n, extexp_pkg::M_LN2_HI, x);
    t = fused_mul_add(n, extexp_pkg::LN2_LO, t);
    p = fused_mul_add(extexp_pkg::K5, t, extexp_pkg::K4);
    p = fused_mul_add(p, t, extexp_pkg::K3);
    p = fused_mul_add(p, t, extexp_pkg::K2);
    p = fused_mul_add(p, t, extexp_pkg::K1);
    p = fused_mul_add(p, t, extexp_pkg::K0);
    r.mantissa = canonical(p);
    r.exponent = canonical(n);
    return r;
  endfunction

  initial fail_count = 0;

  always @(posedge clk_i) begin
    split_exp_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding: mantissa %h exponent %h",
                 mantissa_bits_i, exponent_bits_i);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (mantissa_bits_i !== want.mantissa) begin
            $error("mantissa_bits expected %h actual %h", want.mantissa, mantissa_bits_i);
            fail_count++;
          end
          if (exponent_bits_i !== want.exponent) begin
            $error("exponent_bits expected %h actual %h", want.exponent, exponent_bits_i);
            fail_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(split_exp(x_bits_i));
    end
  end

  always_comb begin
    fail_count_o = fail_count;
    pending_o    = expected_q.size();
  end

endmodule

// ===== verif/extexp_f32_split_mantissa_exponent_test.sv =====
// Testbench top for the split exponential: stimulus, receiver stalls and final verdict.
module extexp_f32_split_mantissa_exponent_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REQUESTS = 1930;
  localparam int CYCLE_LIMIT     = 600000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] x_bits_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] mantissa_bits_o;
  logic [31:0] exponent_bits_o;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  logic        sending_done = 1'b0;

  logic [31:0] directed_x[] = '{
    32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000, 32'h7FC00000, 32'h7F800001,
    32'hFFFFFFFF, 32'h7F7FFFFF, 32'hFF7FFFFF, 32'h00000001, 32'h80000001, 32'h007FFFFF,
    32'hBE99999A, 32'h3F800000, 32'hBF800000, 32'h42B17218, 32'hC2CE0000, 32'h3E317218,
    32'hBE317218, 32'h4B000000, 32'h4AFFFFFF, 32'h3F000000, 32'h42FE0000, 32'hC2FF0000
  };

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("extexp_f32_split_mantissa_exponent verification failed");
      $finish;
    end
  end

  extexp_f32_split_mantissa_exponent i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .x_bits_i        (x_bits_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .mantissa_bits_o (mantissa_bits_o),
    .exponent_bits_o (exponent_bits_o)
  );

  extexp_f32_split_mantissa_exponent_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .x_bits_i        (x_bits_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .mantissa_bits_i (mantissa_bits_o),
    .exponent_bits_i (exponent_bits_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  function automatic int gap_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] random_x();
    if ($urandom_range(0, 99) < 25) return $urandom;
    return {1'($urandom), 8'($urandom_range(100, 134)), 23'($urandom)};
  endfunction

  task automatic send_request(logic [31:0] x);
    int gap;
    gap = sending_done ? 0 : gap_length();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    x_bits_i   <= x;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  initial begin
    int stall_len;
    repeat (12) @(posedge clk_i);
    repeat (600) @(negedge clk_i) out_stall_i <= ($urandom_range(0, 3) == 0);
    @(negedge clk_i) out_stall_i <= 1'b1;
    repeat (300) @(negedge clk_i);
    forever begin
      stall_len = gap_length();
      @(negedge clk_i) out_stall_i <= (stall_len > 0);
      repeat (stall_len) @(negedge clk_i);
      @(negedge clk_i) out_stall_i <= 1'b0;
      repeat ($urandom_range(0, 30)) @(negedge clk_i);
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    foreach (directed_x[i]) send_request(directed_x[i]);
    for (int i = 0; i < RANDOM_REQUESTS; i++) send_request(random_x());
    @(negedge clk_i) in_valid_i <= 1'b0;
    sending_done = 1'b1;
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("extexp_f32_split_mantissa_exponent verification clean");
    end else begin
      $display("extexp_f32_split_mantissa_exponent verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/extexp_pkg.sv
hdl/extexp_fma_cell.sv
hdl/extexp_round_cell.sv
hdl/extexp_f32_split_mantissa_exponent.sv
hdl/extexp_checker.sv
verif/extexp_f32_split_mantissa_exponent_checker.sv
verif/extexp_f32_split_mantissa_exponent_test.sv
